// ===== design/dqs_pkg.sv =====
package dqs_pkg;

    // Request codes
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } command_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // Fixed widths of the result fields
    localparam int unsigned POS_W   = 4;
    localparam int unsigned COUNT_W = 5;

    // Controller to datapath
    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    load_key;
        logic    scan;
        logic    report;
        logic    found;
        status_t res_status;
    } dqs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic last;
    } dqs_stat_t;

endpackage

// ===== design/dqs_ctrl.sv =====
module dqs_ctrl
    import dqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [2:0] command,
    input  dqs_stat_t stat,
    output dqs_cmd_t  cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && command == CMD_SEARCH && !stat.empty)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.res_status = ST_DONE;
        busy           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_PUSH_FRONT:
                        begin
                            cmd.report = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push_front = 1'b1;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            cmd.report = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push_back = 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            cmd.report = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_front = 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            cmd.report = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_back = 1'b1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            // nothing to scan on an empty store
                            if (stat.empty)
                            begin
                                cmd.report = 1'b1;
                            end
                            else
                            begin
                                cmd.load_key = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused codes: report unchanged state
                            cmd.report = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                busy     = 1'b1;
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    cmd.report = 1'b1;
                    cmd.found  = 1'b1;
                end
                else if (stat.last)
                begin
                    cmd.report = 1'b1;
                end
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/dqs_datapath.sv =====
module dqs_datapath
    import dqs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dqs_cmd_t             cmd,
    input  logic signed [31:0]   value,
    output dqs_stat_t            stat,
    output logic                 done,
    output logic [1:0]           status,
    output logic                 found,
    output logic [POS_W-1:0]     position,
    output logic [COUNT_W-1:0]   count,
    output logic                 is_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = PTR_W + 1;

    // Ring storage
    logic signed [31:0] mem [DEPTH];

    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic signed [31:0] key_reg;
    logic [PTR_W-1:0]   scan_slot_reg;
    logic [PTR_W-1:0]   cmp_idx_reg;
    logic signed [31:0] rd_data_reg;

    logic               done_reg;
    status_t            status_reg;
    logic               found_reg;
    logic [POS_W-1:0]   position_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic               is_empty_reg;

    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   head_dec;
    logic [PTR_W-1:0]   scan_inc;
    logic [SUM_W-1:0]   back_sum;
    logic [PTR_W-1:0]   back_slot;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   rd_addr;

    // Ring pointer arithmetic
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);
    assign scan_inc = (scan_slot_reg == PTR_W'(DEPTH - 1)) ?
                      '0 : scan_slot_reg + PTR_W'(1);
    assign back_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ?
                       PTR_W'(back_sum - SUM_W'(DEPTH)) : PTR_W'(back_sum);

    // Status to controller
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.hit   = (rd_data_reg == key_reg);
    assign stat.last  = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);

    // Write port and read address
    assign wr_en   = cmd.push_front || cmd.push_back;
    assign wr_addr = cmd.push_front ? head_dec : back_slot;
    assign rd_addr = cmd.scan ? scan_slot_reg : head_reg;

    // Head and count update
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push_front)
        begin
            head_next  = head_dec;
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.push_back)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop_front)
        begin
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.pop_back)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Queue state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= cmd.report;
        end
    end

    // Search key and scan pointers
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg       <= value;
            scan_slot_reg <= head_inc;
            cmp_idx_reg   <= '0;
        end
        else if (cmd.scan)
        begin
            scan_slot_reg <= scan_inc;
            cmp_idx_reg   <= cmp_idx_reg + PTR_W'(1);
        end
    end

    // Result fields
    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            status_reg    <= cmd.res_status;
            found_reg     <= cmd.found;
            position_reg  <= cmd.found ? POS_W'(cmp_idx_reg) : '0;
            count_out_reg <= COUNT_W'(count_next);
            is_empty_reg  <= (count_next == '0);
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign found    = found_reg;
    assign position = position_reg;
    assign count    = count_out_reg;
    assign is_empty = is_empty_reg;

endmodule

// ===== design/double_ended_queue_with_search_core.sv =====
// Channel   Direction  Handshake        Payload
// request   in         start, busy      command, value
// result    out        done (strobe)    status, found, position, count, is_empty
//
// A request is taken when start is high and busy is low.
// Push, pop and unused codes: result strobe in the cycle after the request;
// another request may be taken in that same cycle, one per clock.
// Search: one entry a cycle through the single read port of the ring memory;
// busy stays high while entries are compared; result in the cycle after the hit or last entry.
// Reset clears head, count, strobe and controller; storage is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall it.
module double_ended_queue_with_search_core
    import dqs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           command,
    input  logic signed [31:0]   value,
    output logic                 done,
    output logic [1:0]           status,
    output logic                 found,
    output logic [POS_W-1:0]     position,
    output logic [COUNT_W-1:0]   count,
    output logic                 is_empty
);

    dqs_cmd_t  cmd;
    dqs_stat_t stat;

    // Controller
    dqs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Datapath
    dqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .value    (value),
        .stat     (stat),
        .done     (done),
        .status   (status),
        .found    (found),
        .position (position),
        .count    (count),
        .is_empty (is_empty)
    );

endmodule
